// ----- rtl/damper_fan_sequencer_defines.svh -----
// Assertion macros used by the damper/fan sequencer checker.
`ifndef DAMPER_FAN_SEQUENCER_DEFINES_SVH
`define DAMPER_FAN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfs check failed: same-cycle implication");

// Next-cycle implication, sampled on clock, off during reset.
`define DFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfs check failed: next-cycle implication");

`endif

// ----- rtl/dfs_pkg.sv -----
// Types and constants for the damper and fan sequencer.
`timescale 1ns / 1ps

package dfs_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int DelayWidth    = 16;
   localparam int TimeWidth     = 32;

   localparam logic [DelayWidth-1:0] DefaultMoveDelay = 16'd180;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrMoveDelay       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrStartOn         = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrTimerInUse      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrHasDamperCmd    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrSingleDamperCmd = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrSingleFanCmd    = 3'd5;

   typedef struct packed {
      logic [DelayWidth-1:0] move_delay_s;
      logic                  start_on;
      logic                  timer_in_use;
      logic                  has_damper_cmd;
      logic                  single_damper_cmd;
      logic                  single_fan_cmd;
   } cfg_type;

   typedef struct packed {
      logic fan_out;
      logic fan_in;
      logic close_m;
      logic open_m;
   } drive_type;

   typedef struct packed {
      logic                 open_flag;
      logic                 opening_flag;
      logic                 closing_flag;
      logic [TimeWidth-1:0] move_start_time;
      drive_type            drive;
   } state_type;

   typedef struct packed {
      logic                 tag_present;
      logic                 timer_enabled;
      logic                 timer_run;
      logic [TimeWidth-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic open_motor;
      logic close_motor;
      logic fan_inlet;
      logic fan_outlet;
      logic is_open;
      logic is_opening;
      logic is_closing;
      logic run_pid;
      logic valves_forced_open;
   } rsp_type;

endpackage

// ----- rtl/dfs_csr.sv -----
// Configuration register file of the damper and fan sequencer.
`timescale 1ns / 1ps

module dfs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfs_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dfs_pkg::CsrDataWidth-1:0]    csr_data,
   output dfs_pkg::cfg_type                    cfg
);
   import dfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrMoveDelay:       cfg_in.move_delay_s      = csr_data;
            CsrStartOn:         cfg_in.start_on          = csr_data[0];
            CsrTimerInUse:      cfg_in.timer_in_use      = csr_data[0];
            CsrHasDamperCmd:    cfg_in.has_damper_cmd    = csr_data[0];
            CsrSingleDamperCmd: cfg_in.single_damper_cmd = csr_data[0];
            CsrSingleFanCmd:    cfg_in.single_fan_cmd    = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_delay_s      <= DefaultMoveDelay;
         cfg_ff.start_on          <= 1'b0;
         cfg_ff.timer_in_use      <= 1'b0;
         cfg_ff.has_damper_cmd    <= 1'b1;
         cfg_ff.single_damper_cmd <= 1'b0;
         cfg_ff.single_fan_cmd    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/dfs_step.sv -----
// Next-state and result logic for one sequencer update.
`timescale 1ns / 1ps

module dfs_step (
   input  dfs_pkg::cfg_type   cfg,
   input  dfs_pkg::state_type state_cur,
   input  dfs_pkg::req_type   req,
   output dfs_pkg::state_type state_nxt,
   output dfs_pkg::rsp_type   rsp
);
   import dfs_pkg::*;

   logic                 settled;
   logic                 any_flag;
   logic                 elapsed;
   logic                 do_open;
   logic                 do_close;
   logic                 pid;
   logic [TimeWidth-1:0] since_move;
   state_type            st;

   assign settled    = state_cur.open_flag & ~state_cur.opening_flag & ~state_cur.closing_flag;
   assign any_flag   = state_cur.open_flag | state_cur.opening_flag | state_cur.closing_flag;
   assign since_move = req.now_seconds - state_cur.move_start_time;
   assign elapsed    = since_move > {{(TimeWidth-DelayWidth){1'b0}}, cfg.move_delay_s};

   // which action this update takes
   always_comb begin
      do_open  = 1'b0;
      do_close = 1'b0;
      pid      = 1'b0;
      priority if (req.tag_present) begin
         do_close = 1'b1;
      end else if (cfg.timer_in_use && req.timer_enabled) begin
         if (req.timer_run) begin
            pid     = settled;
            do_open = ~settled;
         end else begin
            do_close = any_flag;
         end
      end else if (cfg.start_on) begin
         pid     = settled;
         do_open = ~settled;
      end else begin
         do_close = state_cur.open_flag;
      end
   end

   // drive writes to a missing output leave its bit untouched
   always_comb begin
      st = state_cur;
      if (do_open) begin
         if (!cfg.has_damper_cmd) begin
            st.open_flag    = 1'b1;
            st.drive.fan_in = 1'b1;
            if (!cfg.single_fan_cmd) st.drive.fan_out = 1'b1;
         end else if ((!state_cur.open_flag && !state_cur.opening_flag)
                      || state_cur.closing_flag) begin
            if (!cfg.single_damper_cmd) st.drive.close_m = 1'b0;
            st.drive.open_m    = 1'b1;
            st.move_start_time = req.now_seconds;
            st.opening_flag    = 1'b1;
            st.closing_flag    = 1'b0;
         end else if (state_cur.opening_flag && elapsed) begin
            st.drive.open_m = 1'b0;
            if (!cfg.single_damper_cmd) st.drive.close_m = 1'b0;
            st.open_flag    = 1'b1;
            st.opening_flag = 1'b0;
            st.drive.fan_in = 1'b1;
            if (!cfg.single_fan_cmd) st.drive.fan_out = 1'b1;
         end
      end else if (do_close) begin
         if (!cfg.has_damper_cmd) begin
            st.open_flag    = 1'b0;
            st.drive.fan_in = 1'b0;
            if (!cfg.single_fan_cmd) st.drive.fan_out = 1'b0;
         end else if ((state_cur.open_flag && !state_cur.closing_flag)
                      || state_cur.opening_flag) begin
            st.drive.fan_in = 1'b0;
            if (!cfg.single_fan_cmd) st.drive.fan_out = 1'b0;
            st.drive.open_m = 1'b0;
            if (!cfg.single_damper_cmd) st.drive.close_m = 1'b1;
            st.closing_flag    = 1'b1;
            st.opening_flag    = 1'b0;
            st.move_start_time = req.now_seconds;
         end else if (state_cur.closing_flag && elapsed) begin
            st.drive.open_m = 1'b0;
            if (!cfg.single_damper_cmd) st.drive.close_m = 1'b0;
            st.closing_flag = 1'b0;
            st.open_flag    = 1'b0;
         end
      end
   end

   assign state_nxt = st;

   assign rsp.open_motor         = st.drive.open_m;
   assign rsp.close_motor        = st.drive.close_m & ~cfg.single_damper_cmd;
   assign rsp.fan_inlet          = st.drive.fan_in;
   assign rsp.fan_outlet         = st.drive.fan_out & ~cfg.single_fan_cmd;
   assign rsp.is_open            = st.open_flag;
   assign rsp.is_opening         = st.opening_flag;
   assign rsp.is_closing         = st.closing_flag;
   assign rsp.run_pid            = pid;
   assign rsp.valves_forced_open = req.tag_present;

endmodule

// ----- rtl/damper_fan_sequencer.sv -----
// Top level of the air-handler damper and fan sequencer.
`timescale 1ns / 1ps

// Damper and fan sequencer. Each request (tag, timer state, current seconds)
// yields exactly one response with the motor and fan drives, the damper flags,
// the PID hand-over flag and the valve override flag. One request is taken
// every clock cycle unless the response register stalls; each request
// passes the request register, then the response register, before its response
// is offered. The only loop is the damper state update, a few flag decisions
// plus one 32-bit subtract and compare. The user must write registers on the
// csr port while no request is in flight (unenforced); indexes 6, 7 are ignored.
module damper_fan_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dfs_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [dfs_pkg::CsrDataWidth-1:0]   csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_tag_present,
   input  logic                               req_timer_enabled,
   input  logic                               req_timer_run,
   input  logic [dfs_pkg::TimeWidth-1:0]      req_now_seconds,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_open_motor,
   output logic                               rsp_close_motor,
   output logic                               rsp_fan_inlet,
   output logic                               rsp_fan_outlet,
   output logic                               rsp_is_open,
   output logic                               rsp_is_opening,
   output logic                               rsp_is_closing,
   output logic                               rsp_run_pid,
   output logic                               rsp_valves_forced_open
);
   import dfs_pkg::*;

   cfg_type   cfg;
   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   dfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dfs_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .req       (req_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   // held request moves on when the response register is free or draining
   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         rsp_valid_ff <= advance | (rsp_valid_ff & ~rsp_ready);
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.tag_present   <= req_tag_present;
         req_ff.timer_enabled <= req_timer_enabled;
         req_ff.timer_run     <= req_timer_run;
         req_ff.now_seconds   <= req_now_seconds;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_open_motor         = rsp_ff.open_motor;
   assign rsp_close_motor        = rsp_ff.close_motor;
   assign rsp_fan_inlet          = rsp_ff.fan_inlet;
   assign rsp_fan_outlet         = rsp_ff.fan_outlet;
   assign rsp_is_open            = rsp_ff.is_open;
   assign rsp_is_opening         = rsp_ff.is_opening;
   assign rsp_is_closing         = rsp_ff.is_closing;
   assign rsp_run_pid            = rsp_ff.run_pid;
   assign rsp_valves_forced_open = rsp_ff.valves_forced_open;

endmodule

// ----- rtl/dfs_checker.sv -----
// Port-level checks for the damper and fan sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "damper_fan_sequencer_defines.svh"

module dfs_assertions (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_open,
   input logic rsp_is_opening,
   input logic rsp_is_closing,
   input logic rsp_run_pid,
   input logic rsp_valves_forced_open
);

   logic [3:0] rsp_flags;

   assign rsp_flags = {rsp_is_open, rsp_is_opening, rsp_is_closing, rsp_run_pid};

   // a stalled response keeps its damper flags and PID flag
   `DFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_flags))

   `DFS_ASSERT_NOW(a_no_both_travel, rsp_valid, !(rsp_is_opening && rsp_is_closing))

   // PID only runs with the damper settled open
   `DFS_ASSERT_NOW(a_pid_settled, rsp_valid && rsp_run_pid, rsp_is_open && !rsp_is_opening && !rsp_is_closing)

   `DFS_ASSERT_NOW(a_tag_no_pid, rsp_valid && rsp_valves_forced_open, !rsp_run_pid)

endmodule

bind damper_fan_sequencer dfs_assertions u_dfs_checker (.*);
